FILE: hdl/easi_pkg.sv
// shared types, constants and the tanh table for the adaptive separation block
package easi_pkg;

	localparam int CH = 4;
	localparam int CW = (CH > 1) ? $clog2(CH) : 1;
	localparam int XW = 16;
	localparam int BW = 32;
	localparam int AW = 64;
	localparam int SW = 4;
	localparam logic [SW-1:0] STEP_SHIFT_RST = 4'd9;
	localparam logic signed [BW-1:0] ONE_Q24 = 32'sd16777216;
	localparam int TANH_PTS = 17;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_YMAC,
		ST_YOUT,
		ST_GY,
		ST_VMAC,
		ST_UMAC,
		ST_UFIN,
		ST_COPY
	} state_t;

	typedef enum logic [1:0] {
		VT_YY,
		VT_GY,
		VT_YG
	} vterm_t;

	// tanh at 0, 0.5, ... 8.0 in q3.12
	function automatic logic [12:0] tanh_tab(input logic [4:0] idx);
		logic [12:0] r;
		case (idx)
			5'd0: r = 13'd0;
			5'd1: r = 13'd1893;
			5'd2: r = 13'd3119;
			5'd3: r = 13'd3707;
			5'd4: r = 13'd3949;
			5'd5: r = 13'd4041;
			5'd6: r = 13'd4076;
			5'd7: r = 13'd4089;
			5'd8: r = 13'd4093;
			5'd9: r = 13'd4095;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/easi_adaptive_separation.sv
// top level: adaptive blind source separation with one shared multiply-accumulate unit
//
// input words arrive on s_axis (tdata = mixed_sample, q3.12); every CH words
// form one vector x. once the vector is complete the block computes y = B*x
// and sends the CH separated words on m_axis in channel order, tuser holding
// the channel and tlast marking the final one. it then adapts B with the
// natural-gradient rule, B -= 2^-step_shift * (yy' - I + g(y)y' - y g(y)')*B.
// the matrix products go through one 32x32 signed multiplier and a 64-bit
// accumulator, driven by a small sequencer.
// per vector the sequencer computes the y rows, then g(y) for each channel,
// then the V matrix entry by entry, then the B update entry by entry, and
// then commits B. s_axis_tready is high only while collecting, so no new
// word is taken until B is committed. the first y word is registered in
// ST_YOUT, after the ST_YMAC steps of row 0.
// reset sets B to identity, step_shift to 9 and empties the vector.
// a stalled receiver holds the sequencer in the y stage until the output
// register frees up; nothing is dropped.
// cfg_wen/cfg_wdata write step_shift; write it only while idle.
module easi_adaptive_separation
	import easi_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [SW-1:0] cfg_wdata,     // step_shift
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [15:0]   s_axis_tdata,  // [15:0] mixed_sample
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,  // [15:0] separated_sample
	output logic [2:0]    m_axis_tuser,  // [2:0] channel
	output logic          m_axis_tlast   // last_of_vector
);

	state_t state_q, state_d;

	logic [SW-1:0]          shift_q;
	logic signed [BW-1:0]   b_q  [CH][CH];
	logic signed [BW-1:0]   nb_q [CH][CH];
	logic signed [BW-1:0]   v_q  [CH][CH];
	logic signed [XW-1:0]   x_q  [CH];
	logic signed [XW-1:0]   y_q  [CH];
	logic signed [XW-1:0]   gy_q [CH];
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          ri_q, ci_q, ki_q;
	vterm_t                 ti_q;
	logic signed [AW-1:0]   acc_q;

	logic                   out_valid_q;
	logic [XW-1:0]          out_data_q;
	logic [2:0]             out_ch_q;
	logic                   out_last_q;

	// shared multiplier operands
	logic [CW-1:0]          b_row, b_col;
	logic signed [BW-1:0]   b_rd;
	logic signed [BW-1:0]   mul_a, mul_b;
	logic signed [AW-1:0]   prod;
	logic signed [AW-1:0]   acc_v, acc_u;
	logic signed [AW-1:0]   y_rnd;
	logic signed [XW-1:0]   y_sat;
	logic signed [XW-1:0]   g_val;
	logic signed [AW-1:0]   upd, nb_wide;
	logic signed [BW-1:0]   nb_sat;
	logic                   out_free;
	logic                   in_acc;
	logic                   ri_last, ci_last, ki_last;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign ri_last  = (ri_q == CW'(CH - 1));
	assign ci_last  = (ci_q == CW'(CH - 1));
	assign ki_last  = (ki_q == CW'(CH - 1));

	// single read port into B
	always_comb begin
		case (state_q)
			ST_YMAC: begin
				b_row = ri_q;
				b_col = ki_q;
			end
			ST_UMAC: begin
				b_row = ki_q;
				b_col = ci_q;
			end
			default: begin
				b_row = ri_q;
				b_col = ci_q;
			end
		endcase
		b_rd = b_q[b_row][b_col];
	end

	// operand select per phase
	always_comb begin
		case (state_q)
			ST_YMAC: begin
				mul_a = b_rd;
				mul_b = BW'(x_q[ki_q]);
			end
			ST_VMAC: begin
				case (ti_q)
					VT_YY: begin
						mul_a = BW'(y_q[ri_q]);
						mul_b = BW'(y_q[ci_q]);
					end
					VT_GY: begin
						mul_a = BW'(gy_q[ri_q]);
						mul_b = BW'(y_q[ci_q]);
					end
					default: begin
						mul_a = BW'(y_q[ri_q]);
						mul_b = BW'(gy_q[ci_q]);
					end
				endcase
			end
			ST_UMAC: begin
				mul_a = v_q[ri_q][ki_q];
				mul_b = b_rd;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = AW'(mul_a) * AW'(mul_b);
	end

	assign acc_v = (ti_q == VT_YG) ? acc_q - prod : acc_q + prod;
	assign acc_u = acc_q + (prod >>> 16);

	// y rounding and saturation
	always_comb begin
		y_rnd = (acc_q + (64'sd1 <<< 23)) >>> 24;
		if (y_rnd > 64'sd32767) begin
			y_sat = 16'sh7fff;
		end else if (y_rnd < -64'sd32768) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_rnd[XW-1:0];
		end
	end

	easi_gtanh u_gtanh (
		.y (y_q[ri_q]),
		.g (g_val)
	);

	// B update for one entry
	always_comb begin
		upd     = (acc_q + (64'sd1 <<< (7 + 32'(shift_q)))) >>> (8 + 32'(shift_q));
		nb_wide = AW'(b_rd) - upd;
		if (nb_wide > 64'sd2147483647) begin
			nb_sat = 32'sh7fffffff;
		end else if (nb_wide < -64'sd2147483648) begin
			nb_sat = 32'sh80000000;
		end else begin
			nb_sat = nb_wide[BW-1:0];
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: if (in_acc && cnt_q == CW'(CH - 1)) state_d = ST_YMAC;
			ST_YMAC:    if (ki_last) state_d = ST_YOUT;
			ST_YOUT: begin
				if (out_free) state_d = ri_last ? ST_GY : ST_YMAC;
			end
			ST_GY:      if (ri_last) state_d = ST_VMAC;
			ST_VMAC:    if (ti_q == VT_YG && ri_last && ci_last) state_d = ST_UMAC;
			ST_UMAC:    if (ki_last) state_d = ST_UFIN;
			ST_UFIN:    state_d = (ri_last && ci_last) ? ST_COPY : ST_UMAC;
			ST_COPY:    state_d = ST_COLLECT;
			default:    state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters, config, output valid and the B matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= STEP_SHIFT_RST;
			cnt_q       <= '0;
			ri_q        <= '0;
			ci_q        <= '0;
			ki_q        <= '0;
			ti_q        <= VT_YY;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CH; i++) begin
				for (int j = 0; j < CH; j++) begin
					b_q[i][j] <= (i == j) ? ONE_Q24 : '0;
				end
			end
		end else begin
			if (cfg_wen) shift_q <= cfg_wdata;
			// a new word loaded this cycle keeps valid high
			if (out_valid_q && m_axis_tready && !(state_q == ST_YOUT)) out_valid_q <= 1'b0;
			case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						cnt_q <= (cnt_q == CW'(CH - 1)) ? '0 : CW'(cnt_q + 1'b1);
						ri_q  <= '0;
						ki_q  <= '0;
					end
				end
				ST_YMAC: ki_q <= CW'(ki_q + 1'b1);
				ST_YOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ki_q <= '0;
						ri_q <= CW'(ri_q + 1'b1);
					end else if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_GY: begin
					ri_q <= CW'(ri_q + 1'b1);
					ci_q <= '0;
					ti_q <= VT_YY;
				end
				ST_VMAC: begin
					case (ti_q)
						VT_YY: ti_q <= VT_GY;
						VT_GY: ti_q <= VT_YG;
						default: begin
							ti_q <= VT_YY;
							ci_q <= CW'(ci_q + 1'b1);
							if (ci_last) ri_q <= CW'(ri_q + 1'b1);
							ki_q <= '0;
						end
					endcase
				end
				ST_UMAC: ki_q <= CW'(ki_q + 1'b1);
				ST_UFIN: begin
					ki_q <= '0;
					ci_q <= CW'(ci_q + 1'b1);
					if (ci_last) ri_q <= CW'(ri_q + 1'b1);
				end
				ST_COPY: begin
					for (int i = 0; i < CH; i++) begin
						for (int j = 0; j < CH; j++) begin
							b_q[i][j] <= nb_q[i][j];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath storage
	always_ff @(posedge clk) begin
		case (state_q)
			ST_COLLECT: begin
				if (in_acc) x_q[cnt_q] <= $signed(s_axis_tdata);
				acc_q <= '0;
			end
			ST_YMAC: acc_q <= acc_q + prod;
			ST_YOUT: begin
				if (out_free) begin
					y_q[ri_q]  <= y_sat;
					out_data_q <= y_sat;
					out_ch_q   <= 3'(ri_q);
					out_last_q <= ri_last;
					acc_q      <= '0;
				end
			end
			ST_GY: begin
				gy_q[ri_q] <= g_val;
				acc_q      <= '0;
			end
			ST_VMAC: begin
				if (ti_q == VT_YG) begin
					v_q[ri_q][ci_q] <= (ri_q == ci_q) ? BW'(acc_v - AW'(ONE_Q24))
					                                  : BW'(acc_v);
					acc_q <= '0;
				end else begin
					acc_q <= acc_v;
				end
			end
			ST_UMAC: acc_q <= acc_u;
			ST_UFIN: begin
				nb_q[ri_q][ci_q] <= nb_sat;
				acc_q <= '0;
			end
			default: acc_q <= '0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_COLLECT);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ch_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/easi_gtanh.sv
// g(y) = -tanh(y) by table lookup with linear interpolation
module easi_gtanh
	import easi_pkg::*;
(
	input  logic signed [XW-1:0] y,
	output logic signed [XW-1:0] g
);

	logic [16:0]        mag;
	logic [4:0]         idx;
	logic [10:0]        frac;
	logic [12:0]        t_lo;
	logic [12:0]        t_hi;
	logic [12:0]        diff;
	logic [24:0]        prod;
	logic [12:0]        t;

	always_comb begin
		mag  = y[XW-1] ? 17'(-$signed({y[XW-1], y})) : 17'({1'b0, y});
		idx  = mag[15:11] | {mag[16], 4'd0};
		frac = mag[10:0];
		t_lo = tanh_tab(idx);
		t_hi = tanh_tab(5'(idx + 5'd1));
		diff = t_hi - t_lo;
		prod = 25'(diff) * 25'(frac) + 25'd1024;
		if (idx >= 5'(TANH_PTS - 1)) begin
			t = 13'd4096;
		end else begin
			t = t_lo + 13'(prod >> 11);
		end
		g = y[XW-1] ? XW'($signed({3'b000, t})) : XW'(-$signed({3'b000, t}));
	end

endmodule

FILE: test/easi_adaptive_separation_check.sv
// checker for the adaptive separation block: predicts separated words and compares them
`timescale 1ns / 100ps

module easi_adaptive_separation_check
	import easi_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [SW-1:0] cfg_wdata,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tready,
	input  logic [15:0]   s_axis_tdata,
	input  logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  logic [15:0]   m_axis_tdata,
	input  logic [2:0]    m_axis_tuser,
	input  logic          m_axis_tlast,
	output int            pending,
	output int            fails
);

	typedef struct {
		logic signed [15:0] sample;
		logic [2:0]         chan;
		logic               last;
	} sep_word_t;

	// tanh table points in q3.12, 0.5 apart
	localparam int TANH_Q12 [17] = '{0, 1893, 3119, 3707, 3949, 4041, 4076, 4089, 4093,
		4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096};

	logic signed [BW-1:0] unmix [CH*CH];
	logic signed [15:0]   xvec [CH];
	int                   fill;
	logic [SW-1:0]        mu_shift;
	sep_word_t            sep_q [$];

	function automatic int neg_tanh_q12(input int yv);
		int m, idx, frac, t;
		m = (yv < 0) ? -yv : yv;
		idx = m >> 11;
		frac = m & 2047;
		if (idx >= 16)
			t = TANH_Q12[16];
		else
			t = TANH_Q12[idx] + (((TANH_Q12[idx+1] - TANH_Q12[idx]) * frac + 1024) >>> 11);
		return (yv < 0) ? t : -t;
	endfunction

	// y = B*x, queue the words, then the natural-gradient update from old B
	task automatic separate_and_adapt();
		int       yv [CH];
		int       gv [CH];
		longint   vm [CH*CH];
		longint   acc, d, nb;
		sep_word_t w;
		logic signed [BW-1:0] nextb [CH*CH];
		for (int i = 0; i < CH; i++) begin
			acc = 0;
			for (int j = 0; j < CH; j++)
				acc += longint'(unmix[i*CH+j]) * longint'(xvec[j]);
			acc = (acc + (longint'(1) <<< 23)) >>> 24;
			if (acc > 32767) acc = 32767;
			if (acc < -32768) acc = -32768;
			yv[i] = int'(acc);
			gv[i] = neg_tanh_q12(yv[i]);
			w.sample = yv[i][15:0];
			w.chan = i[2:0];
			w.last = (i == CH-1);
			sep_q.push_back(w);
		end
		for (int i = 0; i < CH; i++)
			for (int j = 0; j < CH; j++) begin
				vm[i*CH+j] = longint'(yv[i])*yv[j] + longint'(gv[i])*yv[j]
					- longint'(yv[i])*gv[j];
				if (i == j) vm[i*CH+j] -= longint'(ONE_Q24);
			end
		for (int i = 0; i < CH; i++)
			for (int j = 0; j < CH; j++) begin
				acc = 0;
				for (int k = 0; k < CH; k++)
					acc += (vm[i*CH+k] * longint'(unmix[k*CH+j])) >>> 16;
				d = (acc + (longint'(1) <<< (7 + mu_shift))) >>> (8 + mu_shift);
				nb = longint'(unmix[i*CH+j]) - d;
				if (nb > 64'sh7fffffff) nb = 64'sh7fffffff;
				if (nb < -64'sh80000000) nb = -64'sh80000000;
				nextb[i*CH+j] = nb[31:0];
			end
		unmix = nextb;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH*CH; i++)
				unmix[i] = (i % (CH+1) == 0) ? ONE_Q24 : '0;
			fill = 0;
			mu_shift = STEP_SHIFT_RST;
			sep_q.delete();
			fails = 0;
		end else begin
			if (cfg_wen)
				mu_shift = cfg_wdata;
			// output compared first: a word produced now cannot come from this edge's input
			if (m_axis_tvalid && m_axis_tready) begin
				if (sep_q.size() == 0) begin
					$error("unexpected separated word %h", m_axis_tdata);
					fails++;
				end else begin
					sep_word_t e;
					e = sep_q.pop_front();
					if (m_axis_tdata !== e.sample) begin
						$error("separated_sample: expected %0d, got %0d", e.sample,
							$signed(m_axis_tdata));
						fails++;
					end
					if (m_axis_tuser !== e.chan) begin
						$error("channel: expected %0d, got %0d", e.chan, m_axis_tuser);
						fails++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last_of_vector: expected %0d, got %0d", e.last, m_axis_tlast);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				xvec[fill] = s_axis_tdata;
				fill++;
				if (fill == CH) begin
					fill = 0;
					separate_and_adapt();
				end
			end
		end
	end

	assign pending = sep_q.size();

endmodule

FILE: test/easi_adaptive_separation_test.sv
// testbench top: stimulus, receiver stalls, step size phases and the verdict
`timescale 1ns / 100ps

module easi_adaptive_separation_test;
	import easi_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 250;   // one full vector pass plus margin

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_wen = 1'b0;
	logic [SW-1:0] cfg_wdata = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [15:0]   s_axis_tdata = '0;   // [15:0] mixed_sample
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [15:0]   m_axis_tdata;        // [15:0] separated_sample
	logic [2:0]    m_axis_tuser;        // [2:0] channel
	logic          m_axis_tlast;        // last_of_vector
	int            pending, fails;
	int            cycles = 0;
	int            burst_left = 0;
	int            stall_mode = 0, stall_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	easi_adaptive_separation dut (.*);

	easi_adaptive_separation_check chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall pattern: always ready, coin flip, or mostly stalled, in random stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 300);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// one word, valid left high; sender gaps only between bursts
	task automatic send_word(input logic [15:0] w);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tdata <= w;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// step size change only with the block idle
	task automatic set_step(input logic [SW-1:0] sh);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= sh;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [15:0] rand_sample();
		// half full range, half near unity so B stays in its useful region
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 16'hffff));
		return 16'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	initial begin
		logic [15:0] directed [] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
			16'hffff, 16'h1000, 16'hf000, 16'h0800,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h5555, 16'haaaa};   // last two leave the vector incomplete
		logic [SW-1:0] shifts [] = '{4'd15, 4'd0, 4'd4, 4'd12};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_word(directed[i]);
		// partial vector survives the register write
		for (int p = 0; p < shifts.size(); p++) begin
			set_step(p == 3 ? 4'($urandom_range(1, 14)) : shifts[p]);
			repeat (70) send_word(rand_sample());
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/easi_pkg.sv
hdl/easi_gtanh.sv
hdl/easi_adaptive_separation.sv
test/easi_adaptive_separation_check.sv
test/easi_adaptive_separation_test.sv
